// ----- sv/key_press_hold_detector_core_macros.svh -----
// Assertion macros for the key qualifier RTL
`ifndef KEY_PRESS_HOLD_DETECTOR_CORE_MACROS_SVH
`define KEY_PRESS_HOLD_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside reset
`define KPHD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clk edge, reset included
`define KPHD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KPHD_ASSERT(lbl, prop, msg)
`define KPHD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/kphd_pkg.sv -----
`timescale 1ns / 1ps

package kphd_pkg;

    localparam int TICK_W = 16;
    localparam int CODE_W = 8;
    localparam int CHAN_W = 2;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NO_KEY_CODE  = 2'd3;

    // Register values after reset
    localparam logic [TICK_W-1:0] RST_JITTER_TICKS = 16'd6;
    localparam logic [TICK_W-1:0] RST_PRESS_TICKS  = 16'd50;
    localparam logic [TICK_W-1:0] RST_LONG_TICKS   = 16'd250;
    localparam logic [CODE_W-1:0] RST_NO_KEY_CODE  = 8'd0;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_WAIT     = 3'd3,
        PH_HELD     = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESS        = 2'd0,
        EV_RELEASE      = 2'd1,
        EV_HOLD         = 2'd2,
        EV_HOLD_RELEASE = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [TICK_W-1:0] jitter_ticks;
        logic [TICK_W-1:0] press_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [CODE_W-1:0] no_key_code;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       kind;
        logic [CODE_W-1:0] value;
        logic [CHAN_W-1:0] channel;
    } result_t;

endpackage

// ----- sv/kphd_cfg.sv -----
`timescale 1ns / 1ps

module kphd_cfg
    import kphd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Always ready: every write beat is accepted and written to the addressed register
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index and update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jitter_ticks <= RST_JITTER_TICKS;
            cfg_reg.press_ticks  <= RST_PRESS_TICKS;
            cfg_reg.long_ticks   <= RST_LONG_TICKS;
            cfg_reg.no_key_code  <= RST_NO_KEY_CODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_JITTER_TICKS: cfg_reg.jitter_ticks <= cfg_data;
                REG_PRESS_TICKS:  cfg_reg.press_ticks  <= cfg_data;
                REG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_data;
                REG_NO_KEY_CODE:  cfg_reg.no_key_code  <= cfg_data[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

// ----- sv/kphd_engine.sv -----
`timescale 1ns / 1ps

module kphd_engine
    import kphd_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [CHAN_W-1:0] channel,
    input  logic [CODE_W-1:0] key_code,
    input  cfg_t              cfg,
    output result_t           result
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    phase_t            phase_reg [NUM_CHANNELS];
    logic [TICK_W-1:0] tick_reg  [NUM_CHANNELS];
    logic [CODE_W-1:0] last_reg  [NUM_CHANNELS];

    logic [IDX_W-1:0]  ch_idx;
    logic              in_range;
    logic              none;
    logic              wr_en;
    phase_t            cur_phase;
    logic [TICK_W-1:0] cur_tick;
    logic [CODE_W-1:0] cur_last;
    phase_t            phase_next;
    logic [TICK_W-1:0] tick_next;
    logic [CODE_W-1:0] last_next;
    logic [TICK_W-1:0] tick_inc;

    // Select the channel entry; channels past the last one are dropped
    assign ch_idx    = IDX_W'(channel);
    assign in_range  = ({{(32-CHAN_W){1'b0}}, channel} < 32'(NUM_CHANNELS));
    assign wr_en     = item_valid && in_range;
    assign cur_phase = phase_reg[ch_idx];
    assign cur_tick  = tick_reg[ch_idx];
    assign cur_last  = last_reg[ch_idx];
    assign none      = (key_code == cfg.no_key_code);
    assign tick_inc  = cur_tick + 16'd1;

    // Advance the channel machine for this beat and form its event
    always_comb
    begin
        phase_next     = cur_phase;
        tick_next      = cur_tick;
        last_next      = cur_last;
        result.valid   = 1'b0;
        result.kind    = EV_PRESS;
        result.value   = key_code;
        result.channel = channel;

        case (cur_phase)
            PH_IDLE:
            begin
                if (!none)
                begin
                    last_next  = key_code;
                    tick_next  = '0;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (none)
                begin
                    last_next  = key_code;
                    tick_next  = '0;
                    phase_next = PH_IDLE;
                end
                else if (cur_tick >= cfg.jitter_ticks)
                begin
                    tick_next    = '0;
                    last_next    = key_code;
                    phase_next   = PH_PRESSED;
                    result.valid = 1'b1;
                    result.kind  = EV_PRESS;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_PRESSED, PH_WAIT:
            begin
                if (none)
                begin
                    result.valid = 1'b1;
                    result.kind  = EV_RELEASE;
                    result.value = cur_last;
                    last_next    = key_code;
                    tick_next    = '0;
                    phase_next   = PH_IDLE;
                end
                else if (cur_phase == PH_PRESSED)
                begin
                    if (cur_tick >= cfg.press_ticks)
                    begin
                        tick_next  = '0;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                else if (cur_tick >= cfg.long_ticks)
                begin
                    tick_next    = '0;
                    last_next    = key_code;
                    phase_next   = PH_HELD;
                    result.valid = 1'b1;
                    result.kind  = EV_HOLD;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_HELD:
            begin
                if (none)
                begin
                    result.valid = 1'b1;
                    result.kind  = EV_HOLD_RELEASE;
                    result.value = cur_last;
                    last_next    = key_code;
                    tick_next    = '0;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                // Meaningless phase code: fall back to idle quietly
                tick_next  = '0;
                phase_next = PH_IDLE;
            end
        endcase

        if (!wr_en)
        begin
            result.valid = 1'b0;
        end
    end

    // Write back the channel entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                tick_reg[i]  <= '0;
                last_reg[i]  <= RST_NO_KEY_CODE;
            end
        end
        else if (wr_en)
        begin
            phase_reg[ch_idx] <= phase_next;
            tick_reg[ch_idx]  <= tick_next;
            last_reg[ch_idx]  <= last_next;
        end
    end

endmodule

// ----- sv/key_press_hold_detector_core.sv -----
`timescale 1ns / 1ps

// Per-channel key qualifier with debounce, press, hold and release events.
// One scan beat (channel, key_code) is taken every cycle unless in_stall is
// high; a beat is held in the input register, is qualified against that
// channel's phase, tick count and last code, and its event, if any, is then
// written to the result register and shown on event_kind and friends, one
// beat per cycle sustained while the result side does not stall. Channel state lives in flip-flops
// and is read and written back in the same cycle, so beats for the same
// channel may follow each other directly. A stall on the result side holds
// the input register and shows through on in_stall in the same cycle.
// Scans of channels at or past NUM_CHANNELS are dropped without an event.

module key_press_hold_detector_core
    import kphd_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [CODE_W-1:0]    key_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    event_kind,
    output logic [CODE_W-1:0]    key_value,
    output logic [CHAN_W-1:0]    event_channel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

`include "key_press_hold_detector_core_macros.svh"

    cfg_t              cfg;
    result_t           result;
    logic              advance;

    logic              in_busy_reg;
    logic [CHAN_W-1:0] channel_reg;
    logic [CODE_W-1:0] code_reg;

    logic              out_valid_reg;
    event_kind_t       kind_reg;
    logic [CODE_W-1:0] value_reg;
    logic [CHAN_W-1:0] event_channel_reg;

    kphd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kphd_engine #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_busy_reg && advance),
        .channel    (channel_reg),
        .key_code   (code_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // The held beat moves on whenever the result slot is free or emptying
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_busy_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_busy_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_busy_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            channel_reg <= channel;
            code_reg    <= key_code;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            kind_reg          <= result.kind;
            value_reg         <= result.value;
            event_channel_reg <= result.channel;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign key_value     = value_reg;
    assign event_channel = event_channel_reg;

    // A full, stalled result slot must hold back the input register
    `KPHD_ASSERT(a_stall_backs_up, (in_busy_reg && out_valid_reg && out_stall) |-> in_stall, "input register not held while result stalled")
    // A new event needs a beat that was held in the input register
    `KPHD_ASSERT(a_event_has_beat, $rose(out_valid_reg) |-> $past(in_busy_reg), "event without a held beat")
    // Events only come from channels that exist
    `KPHD_ASSERT(a_event_channel, out_valid_reg |-> ({{(32-CHAN_W){1'b0}}, event_channel_reg} < 32'(NUM_CHANNELS)), "event on a dropped channel")
    // Nothing is held or shown once reset has been seen at an edge
    `KPHD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_reg && !in_busy_reg), "pipeline not empty in reset")

endmodule
